### rtl/imfd_pkg.sv
// Shared types, register codes and reset values for the motion and fall detector.
package imfd_pkg;

	localparam int ACCEL_BITS = 16;
	localparam int ALPHA_W    = 16;
	localparam int THR_W      = 15;
	localparam int CONFIRM_W  = 24;
	localparam int WINDOW_W   = 16;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_ALPHA     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATIONARY_CONFIRM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREEFALL_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMPACT_THRESHOLD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMPACT_WINDOW     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IS_BASE           = 3'd6;

	localparam logic [ALPHA_W-1:0]   RST_GRAVITY_ALPHA      = 16'd655;
	localparam logic [THR_W-1:0]     RST_MOTION_THRESHOLD   = 15'd614;
	localparam logic [CONFIRM_W-1:0] RST_STATIONARY_CONFIRM = 24'd30000;
	localparam logic [THR_W-1:0]     RST_FREEFALL_THRESHOLD = 15'd1638;
	localparam logic [THR_W-1:0]     RST_IMPACT_THRESHOLD   = 15'd10240;
	localparam logic [WINDOW_W-1:0]  RST_IMPACT_WINDOW      = 16'd1000;

	typedef struct packed {
		logic [ALPHA_W-1:0]   gravity_alpha;
		logic [THR_W-1:0]     motion_threshold;
		logic [CONFIRM_W-1:0] stationary_confirm_ms;
		logic [THR_W-1:0]     freefall_threshold;
		logic [THR_W-1:0]     impact_threshold;
		logic [WINDOW_W-1:0]  impact_window_ms;
		logic                 is_base;
	} cfg_t;

	typedef struct packed {
		logic signed [ACCEL_BITS-1:0] accel_x;
		logic signed [ACCEL_BITS-1:0] accel_y;
		logic signed [ACCEL_BITS-1:0] accel_z;
		logic                         sample_ok;
		logic [TIME_W-1:0]            now_ms;
	} sample_t;

	typedef struct packed {
		logic moving;
		logic motion_detected;
		logic fall_detected;
		logic imu_available;
	} result_t;

endpackage

### rtl/imu_motion_and_fall_detector.sv
// Top level of the accelerometer motion and fall detector.
//
// One sample item enters on sample/sample_valid/sample_ready and one result item
// leaves on result/result_valid/result_ready for every sample, in order.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, one register per
// cycle; the user must write it only while no sample is in flight, as the block
// does not enforce this. A good sample with a tracked gravity runs a schedule on
// one shared multiplier: three threshold squares, three raw squares, then per axis
// two partial products of the gravity weight and one dynamic square, each axis
// taking ten steps. The first good sample after a failed read or reset runs only
// the threshold and raw squares and loads gravity from it; a failed read goes
// straight to the final step. sample_ready is high only while the sequencer is idle,
// so one sample is worked on at a time; a new one is taken while the previous
// result still waits. If it still waits when the next result is done, the
// sequencer holds in its final step until the output register frees, and accepts
// nothing meanwhile. Reset clears gravity tracking and fall arming, sets the
// moving flag, and loads the configuration defaults.
module imu_motion_and_fall_detector #(
	parameter int GRAVITY_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  imfd_pkg::sample_t                sample,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	output imfd_pkg::result_t                result,
	output logic                             result_valid,
	input  logic                             result_ready,
	input  logic                             cfg_we,
	input  logic [imfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [imfd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int GW    = imfd_pkg::ACCEL_BITS + GRAVITY_FRAC_BITS;
	localparam int HALFW = (GW + 1) / 2;
	localparam int BASEW = (imfd_pkg::ACCEL_BITS > imfd_pkg::ALPHA_W) ?
		imfd_pkg::ACCEL_BITS : imfd_pkg::ALPHA_W;
	localparam int MUL_W = (HALFW > BASEW) ? HALFW : BASEW;

	imfd_pkg::cfg_t       cfg;
	logic [MUL_W-1:0]     mul_a;
	logic [MUL_W-1:0]     mul_b;
	logic [2*MUL_W-1:0]   mul_prod;

	imfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	imfd_mul #(
		.MUL_W (MUL_W)
	) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	imfd_seq #(
		.GRAVITY_FRAC_BITS (GRAVITY_FRAC_BITS),
		.MUL_W             (MUL_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.mul_a        (mul_a),
		.mul_b        (mul_b),
		.mul_prod     (mul_prod)
	);

endmodule

### rtl/imfd_cfg.sv
// Configuration register bank with write port and reset values.
module imfd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [imfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [imfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output imfd_pkg::cfg_t                    cfg
);

	imfd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity_alpha         <= imfd_pkg::RST_GRAVITY_ALPHA;
			cfg_q.motion_threshold      <= imfd_pkg::RST_MOTION_THRESHOLD;
			cfg_q.stationary_confirm_ms <= imfd_pkg::RST_STATIONARY_CONFIRM;
			cfg_q.freefall_threshold    <= imfd_pkg::RST_FREEFALL_THRESHOLD;
			cfg_q.impact_threshold      <= imfd_pkg::RST_IMPACT_THRESHOLD;
			cfg_q.impact_window_ms      <= imfd_pkg::RST_IMPACT_WINDOW;
			cfg_q.is_base               <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				imfd_pkg::REG_GRAVITY_ALPHA: begin
					cfg_q.gravity_alpha <= cfg_wdata[imfd_pkg::ALPHA_W-1:0];
				end
				imfd_pkg::REG_MOTION_THRESHOLD: begin
					cfg_q.motion_threshold <= cfg_wdata[imfd_pkg::THR_W-1:0];
				end
				imfd_pkg::REG_STATIONARY_CONFIRM: begin
					cfg_q.stationary_confirm_ms <= cfg_wdata[imfd_pkg::CONFIRM_W-1:0];
				end
				imfd_pkg::REG_FREEFALL_THRESHOLD: begin
					cfg_q.freefall_threshold <= cfg_wdata[imfd_pkg::THR_W-1:0];
				end
				imfd_pkg::REG_IMPACT_THRESHOLD: begin
					cfg_q.impact_threshold <= cfg_wdata[imfd_pkg::THR_W-1:0];
				end
				imfd_pkg::REG_IMPACT_WINDOW: begin
					cfg_q.impact_window_ms <= cfg_wdata[imfd_pkg::WINDOW_W-1:0];
				end
				imfd_pkg::REG_IS_BASE: begin
					cfg_q.is_base <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/imfd_mul.sv
// Shared unsigned multiplier with a registered product.
module imfd_mul #(
	parameter int MUL_W = 20
) (
	input  logic                 clk,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic [2*MUL_W-1:0]   prod
);

	logic [2*MUL_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
	end

	assign prod = prod_q;

endmodule

### rtl/imfd_seq.sv
// Sequencer, gravity tracker and decision logic around the shared multiplier.
module imfd_seq #(
	parameter int GRAVITY_FRAC_BITS = 16,
	parameter int MUL_W             = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  imfd_pkg::cfg_t         cfg,
	input  imfd_pkg::sample_t      sample,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	output imfd_pkg::result_t      result,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [MUL_W-1:0]       mul_a,
	output logic [MUL_W-1:0]       mul_b,
	input  logic [2*MUL_W-1:0]     mul_prod
);

	localparam int A   = imfd_pkg::ACCEL_BITS;
	localparam int F   = GRAVITY_FRAC_BITS;
	localparam int GW  = A + F;
	localparam int DW  = GW + 1;
	localparam int H   = (GW + 1) / 2;
	localparam int PW  = GW + imfd_pkg::ALPHA_W;
	localparam int SPW = PW + 1;
	localparam int SQW = (2 * A + 2 > 2 * imfd_pkg::THR_W) ? 2 * A + 2 : 2 * imfd_pkg::THR_W;
	localparam int TW  = imfd_pkg::TIME_W;

	localparam logic signed [DW-1:0] HALF = DW'(1) << (F - 1);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_R_FF  = 5'd1;
	localparam logic [4:0] ST_R_IMP = 5'd2;
	localparam logic [4:0] ST_R_MT  = 5'd3;
	localparam logic [4:0] ST_R_X   = 5'd4;
	localparam logic [4:0] ST_R_Y   = 5'd5;
	localparam logic [4:0] ST_R_Z   = 5'd6;
	localparam logic [4:0] ST_R_RAW = 5'd7;
	localparam logic [4:0] ST_DIFF  = 5'd8;
	localparam logic [4:0] ST_MAG   = 5'd9;
	localparam logic [4:0] ST_LO    = 5'd10;
	localparam logic [4:0] ST_HI    = 5'd11;
	localparam logic [4:0] ST_SUM   = 5'd12;
	localparam logic [4:0] ST_SGN   = 5'd13;
	localparam logic [4:0] ST_UPD   = 5'd14;
	localparam logic [4:0] ST_RND   = 5'd15;
	localparam logic [4:0] ST_SQ    = 5'd16;
	localparam logic [4:0] ST_ACC   = 5'd17;
	localparam logic [4:0] ST_FIN   = 5'd18;

	logic [4:0]              st_q;
	logic [1:0]              ax_q;
	logic signed [A-1:0]     s_q [3];
	logic [A-1:0]            m_q [3];
	logic [TW-1:0]           now_q;
	logic                    ok_q;
	logic signed [GW-1:0]    g_q [3];
	logic                    gvalid_q;
	logic                    moving_q;
	logic                    armed_q;
	logic [TW-1:0]           last_motion_q;
	logic [TW-1:0]           ff_time_q;
	logic [SQW-1:0]          ff2_q;
	logic [SQW-1:0]          imp2_q;
	logic [SQW-1:0]          mt2_q;
	logic [SQW-1:0]          raw2_q;
	logic [SQW-1:0]          dyn2_q;
	logic signed [DW-1:0]    diff_q;
	logic signed [DW-1:0]    r_q;
	logic [GW-1:0]           mdiff_q;
	logic [PW-1:0]           p_q;
	logic signed [SPW-1:0]   sp_q;
	logic [A-1:0]            mdyn_q;
	imfd_pkg::result_t       result_q;
	logic                    res_valid_q;

	logic signed [A-1:0]     s_cur;
	logic signed [GW-1:0]    g_cur;
	logic signed [DW-1:0]    target_dw;
	logic signed [DW-1:0]    g_dw;
	logic signed [SPW-1:0]   delta_full;
	logic signed [DW-1:0]    delta_dw;
	logic signed [DW-1:0]    dyn_s;
	logic [SQW-1:0]          prod_sq;
	logic [TW-1:0]           elapsed_motion;
	logic [TW-1:0]           elapsed_ff;
	logic                    motion;
	logic                    moving_nx;
	logic                    armed_nx;
	logic                    arm_now;
	logic                    fall;
	logic                    res_free;
	logic                    commit;

	assign s_cur      = s_q[ax_q];
	assign g_cur      = g_q[ax_q];
	assign target_dw  = $signed({s_cur[A-1], s_cur, {F{1'b0}}});
	assign g_dw       = $signed({g_cur[GW-1], g_cur});
	assign delta_full = sp_q >>> imfd_pkg::ALPHA_W;
	assign delta_dw   = delta_full[DW-1:0];
	assign dyn_s      = r_q >>> F;
	assign prod_sq    = SQW'(mul_prod);

	assign elapsed_motion = now_q - last_motion_q;
	assign elapsed_ff     = now_q - ff_time_q;
	assign motion         = gvalid_q && (dyn2_q >= mt2_q);
	assign res_free       = !res_valid_q || result_ready;
	assign commit         = (st_q == ST_FIN) && res_free;

	always_comb begin
		moving_nx = moving_q;
		armed_nx  = armed_q;
		arm_now   = 1'b0;
		fall      = 1'b0;
		if (!ok_q) begin
			moving_nx = 1'b1;
		end else begin
			if (motion) begin
				moving_nx = 1'b1;
			end else if (elapsed_motion >= TW'(cfg.stationary_confirm_ms)) begin
				moving_nx = 1'b0;
			end
			if (!cfg.is_base) begin
				if (!armed_q) begin
					if (raw2_q < ff2_q) begin
						armed_nx = 1'b1;
						arm_now  = 1'b1;
					end
				end else if (elapsed_ff > TW'(cfg.impact_window_ms)) begin
					armed_nx = 1'b0;
				end else if (raw2_q > imp2_q) begin
					armed_nx = 1'b0;
					fall     = 1'b1;
				end
			end
		end
	end

	// Drive the shared multiplier for the step at hand; its product returns next cycle.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_R_FF: begin
				mul_a = MUL_W'(cfg.freefall_threshold);
				mul_b = MUL_W'(cfg.freefall_threshold);
			end
			ST_R_IMP: begin
				mul_a = MUL_W'(cfg.impact_threshold);
				mul_b = MUL_W'(cfg.impact_threshold);
			end
			ST_R_MT: begin
				mul_a = MUL_W'(cfg.motion_threshold);
				mul_b = MUL_W'(cfg.motion_threshold);
			end
			ST_R_X: begin
				mul_a = MUL_W'(m_q[0]);
				mul_b = MUL_W'(m_q[0]);
			end
			ST_R_Y: begin
				mul_a = MUL_W'(m_q[1]);
				mul_b = MUL_W'(m_q[1]);
			end
			ST_R_Z: begin
				mul_a = MUL_W'(m_q[2]);
				mul_b = MUL_W'(m_q[2]);
			end
			ST_LO: begin
				mul_a = MUL_W'(mdiff_q[H-1:0]);
				mul_b = MUL_W'(cfg.gravity_alpha);
			end
			ST_HI: begin
				mul_a = MUL_W'(mdiff_q[GW-1:H]);
				mul_b = MUL_W'(cfg.gravity_alpha);
			end
			ST_SQ: begin
				mul_a = MUL_W'(mdyn_q);
				mul_b = MUL_W'(mdyn_q);
			end
			default: begin
			end
		endcase
	end

	// Control and tracked state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			ax_q          <= 2'd0;
			res_valid_q   <= 1'b0;
			gvalid_q      <= 1'b0;
			moving_q      <= 1'b1;
			armed_q       <= 1'b0;
			last_motion_q <= '0;
			ff_time_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				g_q[i] <= '0;
			end
		end else begin
			if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (sample_valid) begin
						st_q <= sample.sample_ok ? ST_R_FF : ST_FIN;
					end
				end
				ST_R_FF:  st_q <= ST_R_IMP;
				ST_R_IMP: st_q <= ST_R_MT;
				ST_R_MT:  st_q <= ST_R_X;
				ST_R_X:   st_q <= ST_R_Y;
				ST_R_Y:   st_q <= ST_R_Z;
				ST_R_Z:   st_q <= ST_R_RAW;
				ST_R_RAW: begin
					ax_q <= 2'd0;
					if (gvalid_q) begin
						st_q <= ST_DIFF;
					end else begin
						// load gravity straight from the first good sample
						for (int i = 0; i < 3; i++) begin
							g_q[i] <= {s_q[i], {F{1'b0}}};
						end
						st_q <= ST_FIN;
					end
				end
				ST_DIFF: st_q <= ST_MAG;
				ST_MAG:  st_q <= ST_LO;
				ST_LO:   st_q <= ST_HI;
				ST_HI:   st_q <= ST_SUM;
				ST_SUM:  st_q <= ST_SGN;
				ST_SGN:  st_q <= ST_UPD;
				ST_UPD: begin
					g_q[ax_q] <= GW'(g_dw + delta_dw);
					st_q      <= ST_RND;
				end
				ST_RND: st_q <= ST_SQ;
				ST_SQ:  st_q <= ST_ACC;
				ST_ACC: begin
					if (ax_q == 2'd2) begin
						st_q <= ST_FIN;
					end else begin
						ax_q <= ax_q + 2'd1;
						st_q <= ST_DIFF;
					end
				end
				ST_FIN: begin
					// hold while the previous result is still waiting
					if (res_free) begin
						st_q        <= ST_IDLE;
						res_valid_q <= 1'b1;
						moving_q    <= moving_nx;
						armed_q     <= armed_nx;
						gvalid_q    <= ok_q;
						if (ok_q && motion) begin
							last_motion_q <= now_q;
						end
						if (arm_now) begin
							ff_time_q <= now_q;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (sample_valid) begin
					s_q[0] <= sample.accel_x;
					s_q[1] <= sample.accel_y;
					s_q[2] <= sample.accel_z;
					ok_q   <= sample.sample_ok;
					now_q  <= sample.now_ms;
				end
			end
			ST_R_FF: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i] <= s_q[i][A-1] ? A'(-s_q[i]) : A'(s_q[i]);
				end
			end
			ST_R_IMP: ff2_q  <= prod_sq;
			ST_R_MT:  imp2_q <= prod_sq;
			ST_R_X:   mt2_q  <= prod_sq;
			ST_R_Y:   raw2_q <= prod_sq;
			ST_R_Z:   raw2_q <= raw2_q + prod_sq;
			ST_R_RAW: begin
				raw2_q <= raw2_q + prod_sq;
				dyn2_q <= '0;
			end
			ST_DIFF: diff_q  <= target_dw - g_dw;
			ST_MAG:  mdiff_q <= GW'(diff_q[DW-1] ? -diff_q : diff_q);
			ST_HI:   p_q     <= PW'(mul_prod);
			ST_SUM:  p_q     <= p_q + (PW'(mul_prod) << H);
			ST_SGN: begin
				// signed product floors toward minus infinity on the shift
				sp_q <= diff_q[DW-1] ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
			end
			ST_UPD: r_q    <= diff_q - delta_dw + HALF;
			ST_RND: mdyn_q <= A'(dyn_s[DW-1] ? -dyn_s : dyn_s);
			ST_ACC: dyn2_q <= dyn2_q + prod_sq;
			default: begin
			end
		endcase
		if (commit) begin
			result_q.moving          <= moving_nx;
			result_q.motion_detected <= ok_q && motion;
			result_q.fall_detected   <= fall;
			result_q.imu_available   <= ok_q;
		end
	end

	assign sample_ready = (st_q == ST_IDLE);
	assign result       = result_q;
	assign result_valid = res_valid_q;

endmodule

### dv/tb_imu_motion_and_fall_detector.sv
// Self-checking testbench for the accelerometer motion and fall detector.
module tb_imu_motion_and_fall_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import imfd_pkg::*;

	localparam int FRAC = 16;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef enum {SH_REST, SH_MOVE, SH_FREEFALL, SH_IMPACT, SH_WILD} shape_e;

	logic                  clk;
	logic                  arst_n = 1'b0;
	sample_t               sample = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	result_t               result;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	imu_motion_and_fall_detector #(.GRAVITY_FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.result(result),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// detector state as the block should hold it
	cfg_t              cfg_m = '{gravity_alpha: RST_GRAVITY_ALPHA,
		motion_threshold: RST_MOTION_THRESHOLD, stationary_confirm_ms: RST_STATIONARY_CONFIRM,
		freefall_threshold: RST_FREEFALL_THRESHOLD, impact_threshold: RST_IMPACT_THRESHOLD,
		impact_window_ms: RST_IMPACT_WINDOW, is_base: 1'b0};
	longint            grav_est[3] = '{0, 0, 0};
	logic              grav_ok = 1'b0;
	logic [TIME_W-1:0] last_move_ms = '0;
	logic              moving_st = 1'b1;
	logic              armed = 1'b0;
	logic [TIME_W-1:0] armed_ms = '0;

	sample_t           pending[$];
	result_t           flags_due[$];
	string             flag_names[4] = '{"moving", "motion_detected", "fall_detected",
		"imu_available"};
	int                mismatches = 0;
	int                pushed = 0;
	int                gap_left = 0;
	int                stall_left = 0;
	int                quiet_cycles = 0;
	bit                idling_on = 1'b1;
	logic [TIME_W-1:0] clock_ms = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// move one axis of the gravity average, return the rounded dynamic part
	function automatic longint track_axis(int axis, longint a);
		longint aim, diff, p, delta, al;
		al = cfg_m.gravity_alpha;
		aim = a <<< FRAC;
		diff = aim - grav_est[axis];
		p = (diff < 0 ? -diff : diff) * al;
		delta = diff >= 0 ? (p >>> 16) : -((p + 65535) >>> 16);
		grav_est[axis] += delta;
		return (aim - grav_est[axis] + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic result_t predict_flags(sample_t s);
		longint ax[3];
		longint raw2, dyn2, d, thr;
		logic [TIME_W-1:0] now;
		logic motion, fall;
		result_t r;
		ax[0] = longint'($signed(s.accel_x));
		ax[1] = longint'($signed(s.accel_y));
		ax[2] = longint'($signed(s.accel_z));
		now = s.now_ms;
		motion = 1'b0;
		fall = 1'b0;
		if (!s.sample_ok) begin
			grav_ok = 1'b0;
			moving_st = 1'b1;
			r = '{moving: 1'b1, motion_detected: 1'b0, fall_detected: 1'b0, imu_available: 1'b0};
			return r;
		end
		raw2 = 0;
		for (int i = 0; i < 3; i++)
			raw2 += ax[i] * ax[i];
		if (!grav_ok) begin
			for (int i = 0; i < 3; i++)
				grav_est[i] = ax[i] <<< FRAC;
			grav_ok = 1'b1;
		end else begin
			dyn2 = 0;
			for (int i = 0; i < 3; i++) begin
				d = track_axis(i, ax[i]);
				dyn2 += d * d;
			end
			thr = cfg_m.motion_threshold;
			motion = dyn2 >= thr * thr;
		end
		if (motion) begin
			last_move_ms = now;
			moving_st = 1'b1;
		end else if (now - last_move_ms >= cfg_m.stationary_confirm_ms) begin
			moving_st = 1'b0;
		end
		if (!cfg_m.is_base) begin
			if (!armed) begin
				thr = cfg_m.freefall_threshold;
				if (raw2 < thr * thr) begin
					armed = 1'b1;
					armed_ms = now;
				end
			end else if (now - armed_ms > cfg_m.impact_window_ms) begin
				armed = 1'b0;
			end else begin
				thr = cfg_m.impact_threshold;
				if (raw2 > thr * thr) begin
					armed = 1'b0;
					fall = 1'b1;
				end
			end
		end
		r.moving = moving_st;
		r.motion_detected = motion;
		r.fall_detected = fall;
		r.imu_available = 1'b1;
		return r;
	endfunction

	task automatic check_flags(result_t got);
		result_t want;
		logic [3:0] gv, wv;
		if (flags_due.size() == 0) begin
			$error("result with no item waiting");
			mismatches++;
			return;
		end
		want = flags_due.pop_front();
		gv = got;
		wv = want;
		for (int i = 0; i < 4; i++)
			if (gv[3-i] !== wv[3-i]) begin
				$error("%s: expected %0b, got %0b", flag_names[i], wv[3-i], gv[3-i]);
				mismatches++;
			end
	endtask

	// sender: present the next item once the current one is taken, at times after a random gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || sample_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				sample_valid <= 1'b0;
			end else if (pending.size() != 0) begin
				sample <= pending.pop_front();
				sample_valid <= 1'b1;
				if (idling_on && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 16);
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// receiver: stall in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			if (idling_on && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 16);
		end
	end

	// check the result first: it belongs to an older item than one taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				check_flags(result);
			if (sample_valid && sample_ready)
				flags_due.push_back(predict_flags(sample));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic int clip(int v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int hard_hit();
		int m;
		m = $urandom_range(10000, 32767);
		return $urandom_range(0, 1) ? m : -m;
	endfunction

	function automatic logic [TIME_W-1:0] next_step(bit tight);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tight)
			return $urandom_range(1, 40);
		if (r < 5)
			return 0;
		if (r < 75)
			return $urandom_range(1, 60);
		if (r < 93)
			return $urandom_range(61, 3000);
		if (r < 98)
			return $urandom_range(3001, 70000);
		return $urandom();
	endfunction

	task automatic push_sample(int x, int y, int z, bit ok, logic [TIME_W-1:0] ms);
		sample_t s;
		s.accel_x = x[ACCEL_BITS-1:0];
		s.accel_y = y[ACCEL_BITS-1:0];
		s.accel_z = z[ACCEL_BITS-1:0];
		s.sample_ok = ok;
		s.now_ms = ms;
		pending.push_back(s);
		pushed++;
	endtask

	task automatic push_shape(shape_e sh, bit ok, bit tight);
		int v[3];
		clock_ms += next_step(tight);
		case (sh)
			SH_REST: begin
				v = '{jitter(200), jitter(200), 4096 + jitter(200)};
			end
			SH_MOVE: begin
				v = '{clip(jitter(8000)), clip(jitter(8000)), clip(4096 + jitter(8000))};
			end
			SH_FREEFALL: begin
				v = '{jitter(600), jitter(600), jitter(600)};
			end
			SH_IMPACT: begin
				v = '{hard_hit(), jitter(3000), hard_hit()};
			end
			default: begin
				v = '{int'($urandom()), int'($urandom()), int'($urandom())};
			end
		endcase
		push_sample(v[0], v[1], v[2], ok, clock_ms);
	endtask

	// mostly fall and rest sequences with random content, some noise and dropouts
	task automatic queue_random(int n);
		int start;
		int unsigned r;
		start = pushed;
		while (pushed - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				push_shape(SH_REST, 1'b1, 1'b0);
				repeat ($urandom_range(1, 3)) push_shape(SH_FREEFALL, 1'b1, 1'b1);
				repeat ($urandom_range(0, 2)) push_shape(SH_REST, 1'b1, 1'b1);
				push_shape(SH_IMPACT, 1'b1, 1'b1);
			end else if (r < 42) begin
				push_shape(SH_FREEFALL, 1'b1, 1'b1);
				push_shape(SH_IMPACT, 1'b1, 1'b0);
			end else if (r < 67) begin
				repeat ($urandom_range(3, 8)) push_shape(SH_REST, 1'b1, 1'b0);
			end else if (r < 80) begin
				repeat ($urandom_range(1, 3)) push_shape(SH_MOVE, 1'b1, 1'b0);
			end else if (r < 90) begin
				push_shape(SH_WILD, 1'b1, 1'b0);
			end else begin
				push_shape(shape_e'($urandom_range(0, 4)), 1'b0, 1'b0);
				push_shape(SH_REST, 1'b1, 1'b0);
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(cfg_t c);
		write_reg(REG_GRAVITY_ALPHA, c.gravity_alpha);
		write_reg(REG_MOTION_THRESHOLD, c.motion_threshold);
		write_reg(REG_STATIONARY_CONFIRM, c.stationary_confirm_ms);
		write_reg(REG_FREEFALL_THRESHOLD, c.freefall_threshold);
		write_reg(REG_IMPACT_THRESHOLD, c.impact_threshold);
		write_reg(REG_IMPACT_WINDOW, c.impact_window_ms);
		write_reg(REG_IS_BASE, c.is_base);
		cfg_m = c;
	endtask

	// hold until every item is taken and every result has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending.size() != 0 || sample_valid || flags_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(cfg_t c, int n, bit split);
		wait_idle();
		write_all(c);
		if (split) begin
			queue_random(n / 2);
			wait_idle();
			queue_random(n - n / 2);
		end else begin
			queue_random(n);
		end
	endtask

	initial begin
		cfg_t rc;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: extremes, arming, window edges, failed reads, time wrap
		push_sample(0, 0, 4096, 1'b1, 32'd0);
		push_sample(0, 0, 4096, 1'b1, 32'd10);
		push_sample(32767, 32767, 32767, 1'b1, 32'd20);
		push_sample(-32768, -32768, -32768, 1'b1, 32'd30);
		push_sample(0, 0, 0, 1'b1, 32'd40);
		push_sample(-32768, 0, 0, 1'b1, 32'd60);
		push_sample(0, 0, 0, 1'b1, 32'd100);
		push_sample(0, 0, 0, 1'b1, 32'd1101);
		push_sample(0, 0, 0, 1'b1, 32'd1102);
		push_sample(20000, 0, 0, 1'b0, 32'd1200);
		push_sample(0, 0, 4096, 1'b1, 32'd1300);
		push_sample(32767, -32768, 0, 1'b1, 32'd2102);
		push_sample(0, 0, 4096, 1'b1, 32'hFFFF_FFF0);
		push_sample(0, 0, 4096, 1'b1, 32'hFFFF_FFFF);
		push_sample(0, 0, 0, 1'b1, 32'h0000_0005);
		push_sample(0, 0, 32767, 1'b1, 32'h0000_0100);
		push_sample(16'h5555, 16'hAAAA, 16'h00FF, 1'b1, 32'hAAAA_5555);
		push_sample(16'hAAAA, 16'h5555, 16'hFF00, 1'b1, 32'h5555_AAAA);
		push_sample(-1, -1, -1, 1'b0, 32'hFFFF_0000);
		clock_ms = 32'hFFFF_0000;

		run_phase('{gravity_alpha: 16'hFFFF, motion_threshold: 15'd0, stationary_confirm_ms: 24'd0,
			freefall_threshold: 15'h7FFF, impact_threshold: 15'd0, impact_window_ms: 16'd0,
			is_base: 1'b0}, 80, 1'b0);
		// zero weight: gravity holds its value, reloaded only from the first good sample after a failed read
		run_phase('{gravity_alpha: 16'd0, motion_threshold: 15'd614, stationary_confirm_ms: 24'd200,
			freefall_threshold: 15'd1638, impact_threshold: 15'd10240, impact_window_ms: 16'd1000,
			is_base: 1'b0}, 80, 1'b0);
		run_phase('{gravity_alpha: 16'd655, motion_threshold: 15'd614, stationary_confirm_ms: 24'd300,
			freefall_threshold: 15'd1638, impact_threshold: 15'd10240, impact_window_ms: 16'd1000,
			is_base: 1'b0}, 150, 1'b1);
		run_phase('{gravity_alpha: 16'd4000, motion_threshold: 15'd1500,
			stationary_confirm_ms: 24'd1000, freefall_threshold: 15'd2000,
			impact_threshold: 15'd8000, impact_window_ms: 16'd500, is_base: 1'b1}, 70, 1'b0);
		run_phase('{gravity_alpha: 16'd1, motion_threshold: 15'h7FFF,
			stationary_confirm_ms: 24'hFF_FFFF, freefall_threshold: 15'd0,
			impact_threshold: 15'h7FFF, impact_window_ms: 16'hFFFF, is_base: 1'b0}, 70, 1'b0);

		rc.gravity_alpha = $urandom_range(1, 65535);
		rc.motion_threshold = $urandom_range(0, 32767);
		rc.stationary_confirm_ms = $urandom_range(0, 16777215);
		rc.freefall_threshold = $urandom_range(0, 32767);
		rc.impact_threshold = $urandom_range(0, 32767);
		rc.impact_window_ms = $urandom_range(0, 65535);
		rc.is_base = $urandom_range(0, 1);
		run_phase(rc, 80, 1'b0);

		wait_idle();
		idling_on = 1'b0;
		run_phase('{gravity_alpha: 16'd20000, motion_threshold: 15'd900,
			stationary_confirm_ms: 24'd50, freefall_threshold: 15'd3000,
			impact_threshold: 15'd6000, impact_window_ms: 16'd2000, is_base: 1'b0}, 100, 1'b0);

		wait_idle();
		repeat (60) @(posedge clk);
		if (flags_due.size() != 0) begin
			$error("results missing: %0d", flags_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
